### src/lps_pkg.sv
// Shared types and constants for the line pixel stepper.
`timescale 1ns / 1ps

package lps_pkg;

    // Coordinate fields on the ports are fixed at this width.
    localparam int COORD_FIELD_W = 12;
    localparam int COLOR_W       = 16;
    localparam int COORD_BITS_DEFAULT = 12;

    typedef logic [COORD_FIELD_W-1:0] t_coord_field;
    typedef logic [COLOR_W-1:0]       t_color;

    typedef enum logic {
        ACT_START = 1'b0,
        ACT_STEP  = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        DIR_NONE = 2'b00,
        DIR_POS  = 2'b01,
        DIR_NEG  = 2'b10
    } t_dir;

    typedef struct packed {
        logic         action;
        t_coord_field x_start;
        t_coord_field y_start;
        t_coord_field x_end;
        t_coord_field y_end;
        t_color       draw_color;
    } t_in_item;

    typedef struct packed {
        t_coord_field pixel_x;
        t_coord_field pixel_y;
        t_color       pixel_color;
        logic         last_pixel;
    } t_out_item;

endpackage

### src/lps_axis.sv
// One axis of the line stepper: delta and direction setup, and the error step.
`timescale 1ns / 1ps

module lps_axis
    import lps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    // Setup side, used when a line is started.
    input  logic [COORD_BITS-1:0]   i_from,
    input  logic [COORD_BITS-1:0]   i_to,
    output logic [COORD_BITS-1:0]   o_mag,
    output t_dir                    o_dir,
    // Step side, used when a pixel is emitted.
    input  logic [COORD_BITS-1:0]   i_cur,
    input  logic [COORD_BITS+1:0]   i_err,
    input  logic [COORD_BITS-1:0]   i_mag,
    input  t_dir                    i_dir,
    input  logic [COORD_BITS-1:0]   i_major,
    output logic [COORD_BITS-1:0]   o_cur,
    output logic [COORD_BITS+1:0]   o_err
);

    localparam int ERR_W = COORD_BITS + 2;

    logic [ERR_W-1:0] sum;
    logic [ERR_W-1:0] major_ext;

    always_comb begin
        if (i_to > i_from) begin
            o_mag = i_to - i_from;
            o_dir = DIR_POS;
        end else if (i_to == i_from) begin
            o_mag = '0;
            o_dir = DIR_NONE;
        end else begin
            o_mag = i_from - i_to;
            o_dir = DIR_NEG;
        end
    end

    assign sum       = i_err + ERR_W'(i_mag);
    assign major_ext = ERR_W'(i_major);

    always_comb begin
        o_err = sum;
        o_cur = i_cur;
        if (sum > major_ext) begin
            o_err = sum - major_ext;
            case (i_dir)
                DIR_POS: o_cur = i_cur + COORD_BITS'(1);
                DIR_NEG: o_cur = i_cur - COORD_BITS'(1);
                default: o_cur = i_cur;
            endcase
        end
    end

endmodule

### src/line_pixel_stepper_top.sv
// Top level of the line pixel stepper: input register, line state and result register.
`timescale 1ns / 1ps

// Usage:
// The input channel (i_in_valid, o_in_ready, i_in_data) takes commands. A start
// command loads two endpoints and a color and produces no pixel. A step command
// emits the current pixel of the active line on the output channel
// (o_out_valid, i_out_ready, o_out_data) and advances the line. A step with no
// active line is consumed silently. A line of major distance D yields D+2
// pixels; the first pixel appears twice and the last carries last_pixel.
// An accepted command is held in the input register, from which its pixel loads
// the result register. Commands are taken one per cycle while the receiver does
// not stall; each axis error accumulator on the line state does its add,
// compare and subtract combinationally. When the receiver stalls, the result
// register holds its pixel and the input register keeps one more command;
// o_in_ready drops only when both are full and the held command would produce
// a pixel.
// Reset (synchronous, active low) empties both registers and drops any line.

module line_pixel_stepper_top
    import lps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int ERR_W  = COORD_BITS + 2;
    localparam int LEFT_W = COORD_BITS + 1;

    logic                  r_in_vld;
    t_in_item              r_in;

    logic                  r_active, n_active;
    logic [COORD_BITS-1:0] r_col, n_col;
    logic [COORD_BITS-1:0] r_row, n_row;
    logic [COORD_BITS-1:0] r_dx, n_dx;
    logic [COORD_BITS-1:0] r_dy, n_dy;
    logic [COORD_BITS-1:0] r_major, n_major;
    t_dir                  r_col_dir, n_col_dir;
    t_dir                  r_row_dir, n_row_dir;
    logic [ERR_W-1:0]      r_col_err, n_col_err;
    logic [ERR_W-1:0]      r_row_err, n_row_err;
    logic [LEFT_W-1:0]     r_left, n_left;
    t_color                r_color, n_color;

    logic                  r_out_vld;
    t_out_item             r_out;

    logic                  is_step;
    logic                  produce;
    logic                  advance;
    logic                  in_fire;

    logic [COORD_BITS-1:0] xs, ys, xe, ye;
    logic [COORD_BITS-1:0] setup_dx, setup_dy;
    t_dir                  setup_col_dir, setup_row_dir;
    logic [COORD_BITS-1:0] step_col, step_row;
    logic [ERR_W-1:0]      step_col_err, step_row_err;
    logic [COORD_BITS-1:0] setup_major;
    logic [LEFT_W-1:0]     left_dec;

    assign is_step = (r_in.action == ACT_STEP);
    assign produce = r_in_vld && is_step && r_active;
    // A command that makes no pixel never waits on the output side.
    assign advance = r_in_vld && (!produce || !r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;
    assign in_fire    = i_in_valid && o_in_ready;

    assign xs = COORD_BITS'(r_in.x_start);
    assign ys = COORD_BITS'(r_in.y_start);
    assign xe = COORD_BITS'(r_in.x_end);
    assign ye = COORD_BITS'(r_in.y_end);

    lps_axis #(.COORD_BITS(COORD_BITS)) u_col_axis (
        .i_from  (xs),
        .i_to    (xe),
        .o_mag   (setup_dx),
        .o_dir   (setup_col_dir),
        .i_cur   (r_col),
        .i_err   (r_col_err),
        .i_mag   (r_dx),
        .i_dir   (r_col_dir),
        .i_major (r_major),
        .o_cur   (step_col),
        .o_err   (step_col_err)
    );

    lps_axis #(.COORD_BITS(COORD_BITS)) u_row_axis (
        .i_from  (ys),
        .i_to    (ye),
        .o_mag   (setup_dy),
        .o_dir   (setup_row_dir),
        .i_cur   (r_row),
        .i_err   (r_row_err),
        .i_mag   (r_dy),
        .i_dir   (r_row_dir),
        .i_major (r_major),
        .o_cur   (step_row),
        .o_err   (step_row_err)
    );

    assign setup_major = (setup_dx > setup_dy) ? setup_dx : setup_dy;
    assign left_dec    = r_left - LEFT_W'(1);

    always_comb begin
        n_active  = r_active;
        n_col     = r_col;
        n_row     = r_row;
        n_dx      = r_dx;
        n_dy      = r_dy;
        n_major   = r_major;
        n_col_dir = r_col_dir;
        n_row_dir = r_row_dir;
        n_col_err = r_col_err;
        n_row_err = r_row_err;
        n_left    = r_left;
        n_color   = r_color;
        if (advance) begin
            if (!is_step) begin
                n_active  = 1'b1;
                n_col     = xs;
                n_row     = ys;
                n_dx      = setup_dx;
                n_dy      = setup_dy;
                n_major   = setup_major;
                n_col_dir = setup_col_dir;
                n_row_dir = setup_row_dir;
                n_col_err = '0;
                n_row_err = '0;
                n_left    = LEFT_W'(setup_major) + LEFT_W'(2);
                n_color   = r_in.draw_color;
            end else if (r_active) begin
                n_left    = left_dec;
                n_active  = (left_dec != '0);
                n_col     = step_col;
                n_row     = step_row;
                n_col_err = step_col_err;
                n_row_err = step_row_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_active  <= 1'b0;
            r_left    <= '0;
        end else begin
            if (in_fire) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance && produce) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            r_active <= n_active;
            r_left   <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_in_data;
        end
        if (advance && produce) begin
            r_out.pixel_x     <= t_coord_field'(r_col);
            r_out.pixel_y     <= t_coord_field'(r_row);
            r_out.pixel_color <= r_color;
            r_out.last_pixel  <= (r_left == LEFT_W'(1));
        end
        r_col     <= n_col;
        r_row     <= n_row;
        r_dx      <= n_dx;
        r_dy      <= n_dy;
        r_major   <= n_major;
        r_col_dir <= n_col_dir;
        r_row_dir <= n_row_dir;
        r_col_err <= n_col_err;
        r_row_err <= n_row_err;
        r_color   <= n_color;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // An active line always has pixels left, an idle one none.
    a_active_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active == (r_left != '0)))
        else $error("line active flag disagrees with pixel count");

    // Error accumulators never exceed the major distance on an active line.
    a_err_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_col_err <= ERR_W'(r_major)) && (r_row_err <= ERR_W'(r_major)))
        else $error("error accumulator exceeds major distance");

    // Emitting the flagged last pixel ends the line.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && produce && (r_left == LEFT_W'(1))) |=> !r_active)
        else $error("line still active after last pixel");

    // A held command is not lost while it waits for the result register.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !advance) |=> r_in_vld && $stable(r_in))
        else $error("stalled command dropped or changed");

endmodule
